// ===== design/position_settle_detector_macros.svh =====
// Assertion macros for the position settle detector checker.
// Self-contained; the checker file includes this header by name.
`ifndef POSITION_SETTLE_DETECTOR_MACROS_SVH
`define POSITION_SETTLE_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psd_pkg.sv =====
// Shared types, codes and constants for the position settle detector.
// No dependencies; every other design file but the macros header imports this package.
package psd_pkg;

  localparam int WINDOW_DEF = 4;
  localparam int POS_W      = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_W    = 8;
  localparam int FILL_OUT_W = 5;
  localparam int STATUS_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BUDGET  = 3'd5;

  // Register values after reset.
  localparam logic signed [CFG_W-1:0] RST_TARGET_LEFT   = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_TARGET_TOP    = 16'sd0;
  localparam logic [CFG_W-1:0]        RST_TARGET_WIDTH  = 16'd1;
  localparam logic [CFG_W-1:0]        RST_TARGET_HEIGHT = 16'd1;
  localparam logic [CFG_W-1:0]        RST_STABLE_RADIUS = 16'd1024;
  localparam logic [FRAME_W-1:0]      RST_FRAME_BUDGET  = 8'd60;

  // Run status codes.
  localparam logic [STATUS_W-1:0] RS_SETTLING = 3'd0;
  localparam logic [STATUS_W-1:0] RS_INSIDE   = 3'd1;
  localparam logic [STATUS_W-1:0] RS_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] RS_BUDGET   = 3'd3;
  localparam logic [STATUS_W-1:0] RS_IDLE     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SQX,
    S_SQY,
    S_TEST,
    S_DIVX,
    S_DIVY,
    S_FIN,
    S_DONE
  } psd_state_t;

  typedef struct packed {
    logic                    first_frame;
    logic                    usable;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } psd_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     run_status;
    logic signed [POS_W-1:0] centroid_x;
    logic signed [POS_W-1:0] centroid_y;
    logic [FILL_OUT_W-1:0]   fill_count;
  } psd_out_t;

  // Window update request from the sequencer.
  typedef struct packed {
    logic clear;
    logic push;
  } psd_win_ctrl_t;

endpackage

// ===== design/psd_window.sv =====
// Sliding position window: shift line of entries, fill count and running sums.
// Depends on psd_pkg.
module psd_window import psd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int CW = $clog2(WINDOW),
  localparam int SUM_W = POS_W + CW,
  localparam int FILL_W = $clog2(WINDOW + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  psd_win_ctrl_t           ctrl,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [CW-1:0]           rd_idx,
  output logic [FILL_W-1:0]       fill,
  output logic signed [SUM_W-1:0] sum_x,
  output logic signed [SUM_W-1:0] sum_y,
  output logic [SUM_W-1:0]        mag_x,
  output logic [SUM_W-1:0]        mag_y
);

  localparam int DIFF_W = SUM_W + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
  localparam logic signed [DIFF_W-1:0] W_DIFF = DIFF_W'(WINDOW);

  logic signed [POS_W-1:0] win_x_r [WINDOW];
  logic signed [POS_W-1:0] win_y_r [WINDOW];
  logic [FILL_W-1:0]       fill_r, fill_nxt, fill_base;
  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_x_base;
  logic signed [SUM_W-1:0] sum_y_r, sum_y_nxt, sum_y_base;
  logic                    full;
  logic signed [DIFF_W-1:0] diff_x, diff_y;

  // The newest entry sits at index 0, the oldest of a full window at the top.
  // The sums are kept up to date, so an evicted entry is subtracted on entry.
  always_comb begin
    fill_base  = ctrl.clear ? '0 : fill_r;
    sum_x_base = ctrl.clear ? SUM_W'(0) : sum_x_r;
    sum_y_base = ctrl.clear ? SUM_W'(0) : sum_y_r;
    full       = (fill_base == FILL_MAX);
    fill_nxt   = fill_base;
    sum_x_nxt  = sum_x_base;
    sum_y_nxt  = sum_y_base;
    if (ctrl.push) begin
      fill_nxt  = full ? fill_base : fill_base + 1'b1;
      sum_x_nxt = sum_x_base + SUM_W'(pos_x)
                  - (full ? SUM_W'(win_x_r[WINDOW-1]) : SUM_W'(0));
      sum_y_nxt = sum_y_base + SUM_W'(pos_y)
                  - (full ? SUM_W'(win_y_r[WINDOW-1]) : SUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      win_x_r[0] <= pos_x;
      win_y_r[0] <= pos_y;
      for (int i = 1; i < WINDOW; i++) begin
        win_x_r[i] <= win_x_r[i-1];
        win_y_r[i] <= win_y_r[i-1];
      end
    end
  end

  // Distance of one entry from the centroid, scaled by the window length.
  always_comb begin
    diff_x = DIFF_W'(win_x_r[rd_idx]) * W_DIFF - DIFF_W'(sum_x_r);
    diff_y = DIFF_W'(win_y_r[rd_idx]) * W_DIFF - DIFF_W'(sum_y_r);
    mag_x  = diff_x[DIFF_W-1] ? SUM_W'(-diff_x) : SUM_W'(diff_x);
    mag_y  = diff_y[DIFF_W-1] ? SUM_W'(-diff_y) : SUM_W'(diff_y);
  end

  assign fill  = fill_r;
  assign sum_x = sum_x_r;
  assign sum_y = sum_y_r;

endmodule

// ===== design/position_settle_detector.sv =====
// Top level of the position settle detector: sequencer, shared multiplier,
// configuration registers and output register. Depends on psd_pkg, psd_window.
//
//   Channel  Ports                         Moves
//   input    in_valid/in_stall/in_data     one frame: first flag, usable flag, x, y
//   output   out_valid/out_stall/out_data  one result: status, centroid, fill
//   config   cfg_we/cfg_idx/cfg_data       one register write, no handshake
//
// A frame that does not complete the window goes from idle straight to the result
// step. A frame that completes it runs load, square-x and square-y for each entry,
// then a test and, when the run settles, divide-x, divide-y and finish: the one
// shared multiplier squares x and y distances per entry, then divides the sums.
// Reset is synchronous and active low; the run is idle until a first frame.
// A waiting result does not block the next input transfer; a later result
// waits in its final step until the output register is free.
module position_settle_detector import psd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psd_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW     = $clog2(WINDOW);
  localparam int SUM_W  = POS_W + CW;
  localparam int MAG_W  = SUM_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int RW     = SUM_W + 3;

  localparam logic [CW-1:0]         IDX_LAST   = CW'(WINDOW - 1);
  localparam logic [FILL_W-1:0]     FILL_LAST  = FILL_W'(WINDOW - 1);
  localparam logic [MAG_W-1:0]      W_MAG      = MAG_W'(WINDOW);
  localparam logic [MAG_W-1:0]      HALF_W     = MAG_W'(WINDOW / 2);
  localparam logic [MAG_W-1:0]      RECIP      = MAG_W'((longint'(1) << SUM_W) / WINDOW);
  localparam logic signed [RW-1:0]  RECT_SCALE = RW'(WINDOW * 256);

  // Configuration registers.
  logic signed [CFG_W-1:0] cfg_left_r, cfg_top_r;
  logic [CFG_W-1:0]        cfg_width_r, cfg_height_r, cfg_radius_r;
  logic [FRAME_W-1:0]      cfg_budget_r;

  // Sequencer and datapath registers.
  psd_state_t              state_r, state_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    run_fin_r, run_fin_nxt;
  logic [FRAME_W-1:0]      frames_r, frames_nxt;
  logic                    fail_r, fail_nxt;
  logic [MAG_W-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt, part_r, part_nxt, lim_r, lim_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic signed [POS_W-1:0] res_cx_r, res_cx_nxt, res_cy_r, res_cy_nxt;
  psd_out_t                out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Window interface.
  psd_win_ctrl_t           win_ctrl;
  logic [FILL_W-1:0]       win_fill;
  logic signed [SUM_W-1:0] win_sum_x, win_sum_y;
  logic [MAG_W-1:0]        win_mag_x, win_mag_y;

  // Shared multiplier.
  logic [MAG_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p;

  // Helpers for the sequencer.
  logic                    in_fire, out_free;
  logic                    fin0;
  logic [FILL_W-1:0]       fill0;
  logic [FRAME_W-1:0]      frames0, frames1;
  logic [PROD_W:0]         dist_sum;
  logic                    dist_over;
  logic [MAG_W-1:0]        rad_scaled;
  logic [MAG_W-1:0]        abs_sx, abs_sy, num_x, num_y;
  logic [MAG_W-1:0]        qe_x, qe_y, rem_x, rem_y, q_x, q_y;
  logic signed [POS_W-1:0] cen_x, cen_y;
  logic [CFG_W-1:0]        w_eff, h_eff;
  logic signed [RW-1:0]    sx_e, sy_e, x_lo, x_hi, y_lo, y_hi;
  logic                    in_rect;

  psd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (win_ctrl),
    .pos_x  (in_data.pos_x),
    .pos_y  (in_data.pos_y),
    .rd_idx (idx_r),
    .fill   (win_fill),
    .sum_x  (win_sum_x),
    .sum_y  (win_sum_y),
    .mag_x  (win_mag_x),
    .mag_y  (win_mag_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_left_r   <= RST_TARGET_LEFT;
      cfg_top_r    <= RST_TARGET_TOP;
      cfg_width_r  <= RST_TARGET_WIDTH;
      cfg_height_r <= RST_TARGET_HEIGHT;
      cfg_radius_r <= RST_STABLE_RADIUS;
      cfg_budget_r <= RST_FRAME_BUDGET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TARGET_LEFT:   cfg_left_r   <= cfg_data;
        CFG_TARGET_TOP:    cfg_top_r    <= cfg_data;
        CFG_TARGET_WIDTH:  cfg_width_r  <= cfg_data;
        CFG_TARGET_HEIGHT: cfg_height_r <= cfg_data;
        CFG_STABLE_RADIUS: cfg_radius_r <= cfg_data;
        CFG_FRAME_BUDGET:  cfg_budget_r <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The radius limit is compared against distances scaled by the window
  // length, so the radius is scaled the same way before squaring.
  assign rad_scaled = MAG_W'(cfg_radius_r) * W_MAG;

  // Sum of the squared distances of the entry just finished: x in part_r, y in prod_r.
  assign dist_sum  = (PROD_W + 1)'(part_r) + (PROD_W + 1)'(prod_r);
  assign dist_over = dist_sum > (PROD_W + 1)'(lim_r);

  // Centroid rounding: magnitude plus half the window, divided by the window
  // length with a reciprocal multiply that may fall one short.
  assign abs_sx = win_sum_x[SUM_W-1] ? MAG_W'(-win_sum_x) : MAG_W'(win_sum_x);
  assign abs_sy = win_sum_y[SUM_W-1] ? MAG_W'(-win_sum_y) : MAG_W'(win_sum_y);
  assign num_x  = abs_sx + HALF_W;
  assign num_y  = abs_sy + HALF_W;
  assign qe_x   = part_r[PROD_W-1:MAG_W];
  assign qe_y   = prod_r[PROD_W-1:MAG_W];
  assign rem_x  = num_x - qe_x * W_MAG;
  assign rem_y  = num_y - qe_y * W_MAG;
  assign q_x    = (rem_x >= W_MAG) ? qe_x + 1'b1 : qe_x;
  assign q_y    = (rem_y >= W_MAG) ? qe_y + 1'b1 : qe_y;
  assign cen_x  = win_sum_x[SUM_W-1] ? POS_W'(-q_x) : POS_W'(q_x);
  assign cen_y  = win_sum_y[SUM_W-1] ? POS_W'(-q_y) : POS_W'(q_y);

  // Half-open rectangle test on the exact centroid, both sides scaled by
  // the window length and the fraction bits. A zero size counts as one.
  assign w_eff   = (cfg_width_r == '0) ? CFG_W'(1) : cfg_width_r;
  assign h_eff   = (cfg_height_r == '0) ? CFG_W'(1) : cfg_height_r;
  assign sx_e    = RW'(win_sum_x);
  assign sy_e    = RW'(win_sum_y);
  assign x_lo    = RW'(cfg_left_r) * RECT_SCALE;
  assign x_hi    = (RW'(cfg_left_r) + signed'(RW'(w_eff))) * RECT_SCALE;
  assign y_lo    = RW'(cfg_top_r) * RECT_SCALE;
  assign y_hi    = (RW'(cfg_top_r) + signed'(RW'(h_eff))) * RECT_SCALE;
  assign in_rect = (sx_e >= x_lo) && (sx_e < x_hi) && (sy_e >= y_lo) && (sy_e < y_hi);

  // A first frame restarts the run before the frame itself is counted.
  assign fin0    = in_data.first_frame ? 1'b0 : run_fin_r;
  assign fill0   = in_data.first_frame ? '0 : win_fill;
  assign frames0 = in_data.first_frame ? '0 : frames_r;
  assign frames1 = frames0 + 1'b1;

  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = dx_r;  mul_b = dx_r;  end
      S_SQY:   begin mul_a = dy_r;  mul_b = dy_r;  end
      S_DIVX:  begin mul_a = num_x; mul_b = RECIP; end
      S_DIVY:  begin mul_a = num_y; mul_b = RECIP; end
      default: begin mul_a = rad_scaled; mul_b = rad_scaled; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    run_fin_nxt    = run_fin_r;
    frames_nxt     = frames_r;
    fail_nxt       = fail_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    prod_nxt       = prod_r;
    part_nxt       = part_r;
    lim_nxt        = lim_r;
    res_status_nxt = res_status_r;
    res_cx_nxt     = res_cx_r;
    res_cy_nxt     = res_cy_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    win_ctrl       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_cx_nxt = '0;
          res_cy_nxt = '0;
          if (fin0) begin
            // No run active: nothing changes, the block reports idle.
            res_status_nxt = RS_IDLE;
            state_nxt      = S_DONE;
          end else begin
            run_fin_nxt    = 1'b0;
            frames_nxt     = frames1;
            win_ctrl.clear = in_data.first_frame || !in_data.usable;
            win_ctrl.push  = in_data.usable;
            if (in_data.usable && (fill0 >= FILL_LAST)) begin
              // This frame fills the window: check every entry.
              idx_nxt   = '0;
              fail_nxt  = 1'b0;
              state_nxt = S_LOAD;
            end else begin
              if (frames1 >= cfg_budget_r) begin
                res_status_nxt = RS_BUDGET;
                run_fin_nxt    = 1'b1;
              end else begin
                res_status_nxt = RS_SETTLING;
              end
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_LOAD: begin
        dx_nxt = win_mag_x;
        dy_nxt = win_mag_y;
        if (idx_r == '0) begin
          lim_nxt = mul_p;
        end else if (dist_over) begin
          fail_nxt = 1'b1;
        end
        state_nxt = S_SQX;
      end

      S_SQX: begin
        prod_nxt  = mul_p;
        state_nxt = S_SQY;
      end

      S_SQY: begin
        part_nxt = prod_r;
        prod_nxt = mul_p;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_TEST;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end

      S_TEST: begin
        // The settle test wins over the budget on the same frame.
        if (!fail_r && !dist_over) begin
          res_status_nxt = in_rect ? RS_INSIDE : RS_OUTSIDE;
          run_fin_nxt    = 1'b1;
          state_nxt      = S_DIVX;
        end else begin
          if (frames_r >= cfg_budget_r) begin
            res_status_nxt = RS_BUDGET;
            run_fin_nxt    = 1'b1;
          end else begin
            res_status_nxt = RS_SETTLING;
          end
          state_nxt = S_DONE;
        end
      end

      S_DIVX: begin
        prod_nxt  = mul_p;
        state_nxt = S_DIVY;
      end

      S_DIVY: begin
        part_nxt  = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        res_cx_nxt = cen_x;
        res_cy_nxt = cen_y;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_nxt.run_status = res_status_r;
          out_nxt.centroid_x = res_cx_r;
          out_nxt.centroid_y = res_cy_r;
          out_nxt.fill_count = FILL_OUT_W'(win_fill);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_fin_r   <= 1'b1;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_fin_r   <= run_fin_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    fail_r       <= fail_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    prod_r       <= prod_nxt;
    part_r       <= part_nxt;
    lim_r        <= lim_nxt;
    res_status_r <= res_status_nxt;
    res_cx_r     <= res_cx_nxt;
    res_cy_r     <= res_cy_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/psd_sva.sv =====
// Port-level assertions for the position settle detector, bound to the top.
// Depends on psd_pkg and position_settle_detector_macros.svh.
`include "position_settle_detector_macros.svh"

module psd_sva import psd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input psd_out_t out_data
);

  `PSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `PSD_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while an item is in work")
  `PSD_ASSERT_IMP(a_fill_range, clk, rst_n, out_valid, out_data.fill_count <= FILL_OUT_W'(WINDOW), "fill count beyond window length")
  `PSD_ASSERT_IMP(a_settle_full, clk, rst_n, out_valid && (out_data.run_status == RS_INSIDE || out_data.run_status == RS_OUTSIDE), out_data.fill_count == FILL_OUT_W'(WINDOW), "settled without a full window")
  `PSD_ASSERT_IMP(a_cen_zero, clk, rst_n, out_valid && out_data.run_status != RS_INSIDE && out_data.run_status != RS_OUTSIDE, out_data.centroid_x == '0 && out_data.centroid_y == '0, "centroid reported while not settled")

endmodule

bind position_settle_detector psd_sva #(
  .WINDOW (WINDOW)
) u_psd_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
